// File: rtl/core/sfod_pkg.sv
// ----------------------------------------------------------------------------
// Spectral flux onset detector package
// Widths, register indexes, reset values and the records passed between units.
// ----------------------------------------------------------------------------
package sfod_pkg;

   localparam int MAG_W        = 16;
   localparam int FLUX_W       = 25;
   localparam int SENS_W       = 12;
   localparam int GAP_W        = 8;
   localparam int RSP_DATA_W   = 32;

   localparam logic [FLUX_W-1:0] FLUX_MAX = {FLUX_W{1'b1}};
   localparam logic [GAP_W-1:0]  GAP_MAX  = {GAP_W{1'b1}};

   // Default geometry of the block.
   localparam int MAX_BINS_DEF      = 256;
   localparam int HISTORY_DEPTH_DEF = 43;

   // Result queue between the decision stage and the result channel.
   localparam int RSP_FIFO_DEPTH = 8;
   localparam int RSP_PTR_W      = $clog2(RSP_FIFO_DEPTH);
   localparam int RSP_CNT_W      = $clog2(RSP_FIFO_DEPTH + 1);

   // Control and status registers.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = FLUX_W;

   localparam logic [CSR_IDX_W-1:0] CSR_FLUX_FLOOR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSITIVITY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GAP     = 2'd2;

   localparam logic [FLUX_W-1:0] FLUX_FLOOR_RST  = 25'd1311; // about 0.02 in Q0.16
   localparam logic [SENS_W-1:0] SENSITIVITY_RST = 12'd384;  // 1.5 in Q4.8
   localparam logic [GAP_W-1:0]  MIN_GAP_RST     = 8'd4;

   // Completed frame leaving the bin stage.
   typedef struct packed {
      logic              valid;
      logic [FLUX_W-1:0] flux;
   } frame_end_type;

   // Decision for one frame.
   typedef struct packed {
      logic              valid;
      logic              onset;
      logic [FLUX_W-1:0] flux;
   } result_type;

endpackage

// File: rtl/core/sfod_flux.sv
// ----------------------------------------------------------------------------
// Spectral flux bin stage
// Holds the previous frame's magnitudes and accumulates the rectified flux.
// ----------------------------------------------------------------------------
module sfod_flux #(
   parameter int MAX_BINS = sfod_pkg::MAX_BINS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [sfod_pkg::MAG_W-1:0]  magnitude,
   input  logic                        last_bin,
   output logic                        clear_busy,
   output sfod_pkg::frame_end_type     frame_end
);

   localparam int POS_W  = $clog2(MAX_BINS + 1);
   localparam int ADDR_W = $clog2(MAX_BINS);

   logic [sfod_pkg::MAG_W-1:0] prev_mem [MAX_BINS];

   logic [POS_W-1:0]            bin_pos_ff, bin_pos_in;
   logic                        in_active;

   logic                        s1_valid_ff;
   logic                        s1_active_ff;
   logic                        s1_last_ff;
   logic [sfod_pkg::MAG_W-1:0]  s1_mag_ff;
   logic [ADDR_W-1:0]           s1_addr_ff;
   logic [sfod_pkg::MAG_W-1:0]  old_ff;

   logic [sfod_pkg::FLUX_W-1:0] acc_ff, acc_in, acc_new;
   logic [sfod_pkg::MAG_W-1:0]  diff;
   logic [sfod_pkg::FLUX_W:0]   acc_sum;

   logic                        clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0]           clr_idx_ff, clr_idx_in;

   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [sfod_pkg::MAG_W-1:0]  wr_data;

   sfod_pkg::frame_end_type     fe_ff, fe_in;

   // Bin 0 and bins beyond the stored range take no part in the flux.
   assign in_active = (bin_pos_ff != '0) && (bin_pos_ff < POS_W'(MAX_BINS));

   always_comb begin
      bin_pos_in = bin_pos_ff;
      if (accept) begin
         if (last_bin) begin
            bin_pos_in = '0;
         end else if (bin_pos_ff < POS_W'(MAX_BINS)) begin
            bin_pos_in = bin_pos_ff + POS_W'(1);
         end
      end
   end

   // Rectified difference against the previous frame, saturating sum.
   always_comb begin
      diff    = (s1_mag_ff > old_ff) ? (s1_mag_ff - old_ff) : '0;
      acc_sum = {1'b0, acc_ff} + {{(sfod_pkg::FLUX_W + 1 - sfod_pkg::MAG_W){1'b0}}, diff};
      if (!s1_active_ff) begin
         acc_new = acc_ff;
      end else if (acc_sum > {1'b0, sfod_pkg::FLUX_MAX}) begin
         acc_new = sfod_pkg::FLUX_MAX;
      end else begin
         acc_new = acc_sum[sfod_pkg::FLUX_W-1:0];
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (s1_valid_ff) begin
         acc_in = s1_last_ff ? '0 : acc_new;
      end
      fe_in.valid = s1_valid_ff && s1_last_ff;
      fe_in.flux  = acc_new;
   end

   // After reset the history memory is swept to zero, one entry a cycle.
   always_comb begin
      clr_idx_in  = clr_idx_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + ADDR_W'(1);
         if (clr_idx_ff == ADDR_W'(MAX_BINS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   // Successive accesses to one bin are at least two transfers apart, so the
   // write-back always lands before the next read of the same entry.
   always_comb begin
      wr_en   = clr_busy_ff || (s1_valid_ff && s1_active_ff);
      wr_addr = clr_busy_ff ? clr_idx_ff : s1_addr_ff;
      wr_data = clr_busy_ff ? '0 : s1_mag_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         prev_mem[wr_addr] <= wr_data;
      end
      if (accept && in_active) begin
         old_ff <= prev_mem[bin_pos_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_pos_ff  <= '0;
         s1_valid_ff <= 1'b0;
         acc_ff      <= '0;
         fe_ff       <= '0;
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         bin_pos_ff  <= bin_pos_in;
         s1_valid_ff <= accept;
         acc_ff      <= acc_in;
         fe_ff       <= fe_in;
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_active_ff <= in_active;
      s1_last_ff   <= last_bin;
      s1_mag_ff    <= magnitude;
      s1_addr_ff   <= bin_pos_ff[ADDR_W-1:0];
   end

   assign clear_busy = clr_busy_ff;
   assign frame_end  = fe_ff;

endmodule

// File: rtl/core/sfod_decide.sv
// ----------------------------------------------------------------------------
// Spectral flux onset decision
// Keeps the flux window in memory with a running sum and decides onsets.
// ----------------------------------------------------------------------------
module sfod_decide #(
   parameter int HISTORY_DEPTH = sfod_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sfod_pkg::frame_end_type      frame_end,
   input  logic [sfod_pkg::FLUX_W-1:0]  flux_floor,
   input  logic [sfod_pkg::SENS_W-1:0]  sensitivity,
   input  logic [sfod_pkg::GAP_W-1:0]   min_gap,
   output sfod_pkg::result_type         result
);

   localparam int FW     = sfod_pkg::FLUX_W;
   localparam int SLOT_W = $clog2(HISTORY_DEPTH);
   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W  = FW + CNT_W;
   localparam int LHS_W  = FW + CNT_W;
   localparam int RHS_W  = sfod_pkg::SENS_W + SUM_W;
   localparam int CMP_W  = ((LHS_W + 8) > RHS_W) ? (LHS_W + 8) : RHS_W;

   logic [FW-1:0]    hist_mem [HISTORY_DEPTH];
   logic [FW-1:0]    hist_rd_ff;

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              primed_ff, primed_in;
   logic [FW-1:0]     old_flux;

   logic              s3_valid_ff;
   logic              s3_prime_ff;
   logic              s3_floor_ok_ff;
   logic [FW-1:0]     s3_flux_ff;
   logic [LHS_W-1:0]  lhs_ff, lhs_in;
   logic [RHS_W-1:0]  rhs_ff, rhs_in;

   logic [sfod_pkg::GAP_W-1:0] gap_ff, gap_in, gap_inc;
   logic              ratio_ok;
   logic              onset;

   // Until the window has filled, the slot being replaced was never written.
   assign old_flux = (count_ff == CNT_W'(HISTORY_DEPTH)) ? hist_rd_ff : '0;

   always_comb begin
      slot_in   = slot_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      primed_in = primed_ff;
      if (frame_end.valid) begin
         slot_in   = (slot_ff == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + SLOT_W'(1);
         count_in  = (count_ff < CNT_W'(HISTORY_DEPTH)) ? count_ff + CNT_W'(1) : count_ff;
         sum_in    = sum_ff - {{CNT_W{1'b0}}, old_flux} + {{CNT_W{1'b0}}, frame_end.flux};
         primed_in = 1'b1;
      end
   end

   // Products use the window as it stood before this frame entered it.
   always_comb begin
      lhs_in = {{CNT_W{1'b0}}, frame_end.flux} * {{FW{1'b0}}, count_ff};
      rhs_in = {{SUM_W{1'b0}}, sensitivity} * {{sfod_pkg::SENS_W{1'b0}}, sum_ff};
   end

   // The read address is the slot that will be current next cycle, which
   // differs from the slot written this cycle.
   always_ff @(posedge clock) begin
      if (frame_end.valid) begin
         hist_mem[slot_ff] <= frame_end.flux;
      end
      hist_rd_ff <= hist_mem[slot_in];
   end

   always_comb begin
      gap_inc  = (gap_ff == sfod_pkg::GAP_MAX) ? gap_ff : gap_ff + 8'd1;
      ratio_ok = CMP_W'({lhs_ff, 8'd0}) > CMP_W'(rhs_ff);
      onset    = !s3_prime_ff && s3_floor_ok_ff && ratio_ok && (gap_inc >= min_gap);
      gap_in   = gap_ff;
      if (s3_valid_ff && !s3_prime_ff) begin
         gap_in = onset ? '0 : gap_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff     <= '0;
         count_ff    <= '0;
         sum_ff      <= '0;
         primed_ff   <= 1'b0;
         s3_valid_ff <= 1'b0;
         gap_ff      <= '0;
      end else begin
         slot_ff     <= slot_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         primed_ff   <= primed_in;
         s3_valid_ff <= frame_end.valid;
         gap_ff      <= gap_in;
      end
   end

   always_ff @(posedge clock) begin
      s3_prime_ff    <= !primed_ff;
      s3_floor_ok_ff <= frame_end.flux > flux_floor;
      s3_flux_ff     <= frame_end.flux;
      lhs_ff         <= lhs_in;
      rhs_ff         <= rhs_in;
   end

   assign result.valid = s3_valid_ff;
   assign result.onset = onset;
   assign result.flux  = s3_flux_ff;

endmodule

// File: rtl/core/spectral_flux_onset_detector_top.sv
// ----------------------------------------------------------------------------
// Spectral flux onset detector
// Streams spectrum magnitudes one bin a transfer; reports frame flux and onset.
// ----------------------------------------------------------------------------
// Usage. Each req_ transfer carries one bin magnitude in req_tdata; req_tlast
// marks the final bin of a frame. Exactly one rsp_ transfer follows every
// frame: rsp_tdata holds the rectified flux and rsp_tuser the onset flag.
// The first frame after reset only primes the history and never is an onset.
// Throughput is one bin per clock while req_tready is high: the previous-frame
// memory does one read and one write-back per cycle, and the flux window takes
// one update a cycle, so frames as short as one bin may follow back to back.
// The result of a frame passes the bin stage, the window update with the
// products and the decision, and is then queued before it appears on rsp_.
// After reset the previous-frame memory is swept to zero, entry by entry, and
// req_tready stays low meanwhile; csr_ writes are taken as ever. Results wait
// in an eight-entry queue, so a stalled receiver does not halt input straight
// away; once eight results are owed, req_tready falls until the receiver takes
// one. Write registers only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module spectral_flux_onset_detector_top #(
   parameter int MAX_BINS      = sfod_pkg::MAX_BINS_DEF,
   parameter int HISTORY_DEPTH = sfod_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sfod_pkg::MAG_W-1:0]         req_tdata,   // [15:0] magnitude
   input  logic                               req_tlast,   // last_bin
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sfod_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [24:0] frame_flux, rest zero
   output logic [0:0]                         rsp_tuser,   // [0] onset
   input  logic                               csr_we,
   input  logic [sfod_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sfod_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int FD = sfod_pkg::RSP_FIFO_DEPTH;

   logic [sfod_pkg::FLUX_W-1:0] flux_floor_ff;
   logic [sfod_pkg::SENS_W-1:0] sensitivity_ff;
   logic [sfod_pkg::GAP_W-1:0]  min_gap_ff;

   logic                        req_accept;
   logic                        rsp_accept;
   logic                        clear_busy;
   sfod_pkg::frame_end_type     frame_end;
   sfod_pkg::result_type        result;

   // Results owed: frames whose last bin was taken but whose result has not
   // yet been transferred. Bounding it keeps the queue from overflowing.
   logic [sfod_pkg::RSP_CNT_W-1:0] pending_ff, pending_in;

   sfod_pkg::result_type           fifo_ff [FD];
   logic [sfod_pkg::RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sfod_pkg::RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sfod_pkg::RSP_CNT_W-1:0] fifo_cnt_ff, fifo_cnt_in;
   sfod_pkg::result_type           head;

   assign req_tready = !clear_busy && (pending_ff < sfod_pkg::RSP_CNT_W'(FD));
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   // Register writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         flux_floor_ff  <= sfod_pkg::FLUX_FLOOR_RST;
         sensitivity_ff <= sfod_pkg::SENSITIVITY_RST;
         min_gap_ff     <= sfod_pkg::MIN_GAP_RST;
      end else if (csr_we) begin
         case (csr_index)
            sfod_pkg::CSR_FLUX_FLOOR: begin
               flux_floor_ff <= csr_wdata;
            end
            sfod_pkg::CSR_SENSITIVITY: begin
               sensitivity_ff <= csr_wdata[sfod_pkg::SENS_W-1:0];
            end
            sfod_pkg::CSR_MIN_GAP: begin
               min_gap_ff <= csr_wdata[sfod_pkg::GAP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   sfod_flux #(
      .MAX_BINS (MAX_BINS)
   ) u_flux (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .magnitude  (req_tdata),
      .last_bin   (req_tlast),
      .clear_busy (clear_busy),
      .frame_end  (frame_end)
   );

   sfod_decide #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_decide (
      .clock       (clock),
      .reset       (reset),
      .frame_end   (frame_end),
      .flux_floor  (flux_floor_ff),
      .sensitivity (sensitivity_ff),
      .min_gap     (min_gap_ff),
      .result      (result)
   );

   always_comb begin
      pending_in = pending_ff;
      if ((req_accept && req_tlast) && !rsp_accept) begin
         pending_in = pending_ff + sfod_pkg::RSP_CNT_W'(1);
      end else if (!(req_accept && req_tlast) && rsp_accept) begin
         pending_in = pending_ff - sfod_pkg::RSP_CNT_W'(1);
      end
   end

   // Result queue.
   always_comb begin
      wr_ptr_in   = result.valid ? wr_ptr_ff + sfod_pkg::RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in   = rsp_accept ? rd_ptr_ff + sfod_pkg::RSP_PTR_W'(1) : rd_ptr_ff;
      fifo_cnt_in = fifo_cnt_ff;
      if (result.valid && !rsp_accept) begin
         fifo_cnt_in = fifo_cnt_ff + sfod_pkg::RSP_CNT_W'(1);
      end else if (!result.valid && rsp_accept) begin
         fifo_cnt_in = fifo_cnt_ff - sfod_pkg::RSP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         fifo_ff[wr_ptr_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         pending_ff  <= pending_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         fifo_cnt_ff <= fifo_cnt_in;
      end
   end

   assign head       = fifo_ff[rd_ptr_ff];
   assign rsp_tvalid = (fifo_cnt_ff != '0);
   assign rsp_tdata  = {{(sfod_pkg::RSP_DATA_W - sfod_pkg::FLUX_W){1'b0}}, head.flux};
   assign rsp_tuser  = head.onset;

   // The queue is never written when it is already full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> (fifo_cnt_ff != sfod_pkg::RSP_CNT_W'(FD)))
      else $error("result queue overflow");

   // Queued results never outnumber the results owed.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff <= pending_ff)
      else $error("more queued results than frames taken");

   // No bin is taken while the previous-frame memory is being cleared.
   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_accept)
      else $error("bin taken during memory clear");

   // A frame's result reaches the queue once its last bin has passed the bin and decision stages.
   a_result_timing: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |-> ##3 result.valid)
      else $error("frame result missing");

endmodule

// File: sim/spectral_flux_onset_detector_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Spectral flux onset detector testbench
// Streams spectrum frames into the detector and checks every frame result
// (flux and onset flag) against a cycle-free predictor kept in this bench.
// ----------------------------------------------------------------------------
module spectral_flux_onset_detector_top_tb;

   localparam int BINS  = sfod_pkg::MAX_BINS_DEF;
   localparam int DEPTH = sfod_pkg::HISTORY_DEPTH_DEF;

   // Index 3 has no register behind it; writes there must be ignored.
   localparam logic [sfod_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam logic [sfod_pkg::MAG_W-1:0] MAG_FULL = 16'hFFFF;

   // One frame result as the detector reports it.
   typedef struct packed {
      logic                        onset;
      logic [sfod_pkg::FLUX_W-1:0] flux;
   } frame_result_type;

   // One row of the directed table. Where known is set, the expected result is
   // typed in the row; otherwise the predictor supplies it.
   typedef struct packed {
      logic [sfod_pkg::MAG_W-1:0]  mag;
      logic                        last;
      logic                        known;
      logic                        onset;
      logic [sfod_pkg::FLUX_W-1:0] flux;
   } bin_row_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [sfod_pkg::MAG_W-1:0]      req_tdata  = '0;    // [15:0] magnitude
   logic                            req_tlast  = 1'b0;  // last_bin
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [sfod_pkg::RSP_DATA_W-1:0] rsp_tdata;          // [24:0] frame_flux, rest zero
   logic [0:0]                      rsp_tuser;          // [0] onset
   logic                            csr_we     = 1'b0;
   logic [sfod_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [sfod_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   spectral_flux_onset_detector_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 10 ns clock.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ------------------------------------------------------------------------
   // Predictor state. It mirrors the detector's registers and memories, and is
   // advanced once for every bin transfer that the detector accepts.
   // ------------------------------------------------------------------------
   logic [sfod_pkg::FLUX_W-1:0] cfg_floor = sfod_pkg::FLUX_FLOOR_RST;
   logic [sfod_pkg::SENS_W-1:0] cfg_sens  = sfod_pkg::SENSITIVITY_RST;
   logic [sfod_pkg::GAP_W-1:0]  cfg_gap   = sfod_pkg::MIN_GAP_RST;

   logic [sfod_pkg::MAG_W-1:0]  prev_mag [BINS];
   int                          bin_index        = 0;
   logic [sfod_pkg::FLUX_W-1:0] flux_acc         = '0;
   logic [sfod_pkg::FLUX_W-1:0] flux_window [DEPTH];
   logic [30:0]                 window_sum       = '0;
   int                          window_slot      = 0;
   int                          window_fill      = 0;
   logic [sfod_pkg::GAP_W-1:0]  gap_count        = '0;
   bit                          seen_first_frame = 1'b0;

   // Expected frame results, oldest first.
   frame_result_type owed_frames [$];

   // Flow control: percentage of cycles in which each side holds back.
   int unsigned send_idle_pct = 17;
   int unsigned recv_idle_pct = 48;

   int mismatch_count   = 0;
   int bins_sent        = 0;
   int frames_checked   = 0;
   int onsets_seen      = 0;
   int settings_applied = 1;

   // The directed part, with the reset register values throughout.
   // The first frame primes the window: flux is bin 1 alone, since bin 0 is
   // never compared. A one-bin frame has no flux. A frame that only falls has
   // no flux. Later rows rise steeply to give an onset, then rise again too
   // soon after it, so that the minimum gap holds the flag back.
   bin_row_type directed_rows [0:19] = '{
      '{MAG_FULL, 1'b0, 1'b0, 1'b0, 25'd0},
      '{MAG_FULL, 1'b1, 1'b1, 1'b0, 25'd65535},
      '{16'd1234, 1'b1, 1'b1, 1'b0, 25'd0},
      '{16'd0,    1'b0, 1'b0, 1'b0, 25'd0},
      '{16'd0,    1'b1, 1'b1, 1'b0, 25'd0},
      '{16'd0,    1'b0, 1'b0, 1'b0, 25'd0},
      '{MAG_FULL, 1'b0, 1'b0, 1'b0, 25'd0},
      '{MAG_FULL, 1'b1, 1'b0, 1'b0, 25'd0},
      '{16'd7,    1'b0, 1'b0, 1'b0, 25'd0},
      '{16'd0,    1'b0, 1'b0, 1'b0, 25'd0},
      '{16'd0,    1'b0, 1'b0, 1'b0, 25'd0},
      '{16'd0,    1'b1, 1'b1, 1'b0, 25'd0},
      '{16'd0,    1'b0, 1'b0, 1'b0, 25'd0},
      '{MAG_FULL, 1'b0, 1'b0, 1'b0, 25'd0},
      '{MAG_FULL, 1'b0, 1'b0, 1'b0, 25'd0},
      '{MAG_FULL, 1'b1, 1'b0, 1'b0, 25'd0},
      '{16'd0,    1'b0, 1'b0, 1'b0, 25'd0},
      '{16'd1,    1'b1, 1'b0, 1'b0, 25'd0},
      '{16'd0,    1'b0, 1'b0, 1'b0, 25'd0},
      '{MAG_FULL, 1'b1, 1'b0, 1'b0, 25'd0}
   };

   // Adds a frame flux to the window of past fluxes, dropping the oldest once
   // the window is full, and keeps the running sum in step.
   function automatic void push_window(input logic [sfod_pkg::FLUX_W-1:0] flux);
      window_sum = window_sum - flux_window[window_slot] + flux;
      flux_window[window_slot] = flux;
      window_slot = (window_slot + 1 == DEPTH) ? 0 : window_slot + 1;
      if (window_fill < DEPTH)
         window_fill++;
   endfunction

   // Advances the predictor by one bin. Returns 1 when the bin closes a frame,
   // with the frame's expected result in res.
   function automatic bit predict_bin(input logic [sfod_pkg::MAG_W-1:0] mag,
                                      input logic last,
                                      output frame_result_type res);
      logic [31:0]                 grown;
      logic [sfod_pkg::FLUX_W-1:0] flux;
      bit                          ratio_ok;
      longint unsigned             lhs;
      longint unsigned             rhs;
      res = '0;
      // Bins past the end of the memory are dropped; bin 0 is never compared.
      if (bin_index < BINS) begin
         if (bin_index != 0) begin
            if (mag > prev_mag[bin_index]) begin
               grown = 32'(flux_acc) + 32'(mag) - 32'(prev_mag[bin_index]);
               flux_acc = (grown > 32'(sfod_pkg::FLUX_MAX)) ? sfod_pkg::FLUX_MAX
                                                            : grown[sfod_pkg::FLUX_W-1:0];
            end
            prev_mag[bin_index] = mag;
         end
         bin_index++;
      end
      if (!last)
         return 1'b0;
      flux = flux_acc;
      flux_acc = '0;
      bin_index = 0;
      if (!seen_first_frame) begin
         seen_first_frame = 1'b1;
         push_window(flux);
      end else begin
         // The mean threshold is tested by cross-multiplication, against the
         // window as it stood before this frame.
         if (window_fill == 0) begin
            ratio_ok = (flux != 0);
         end else begin
            lhs = 64'(flux) * 64'(window_fill) * 64'd256;
            rhs = 64'(cfg_sens) * 64'(window_sum);
            ratio_ok = (lhs > rhs);
         end
         push_window(flux);
         if (gap_count != sfod_pkg::GAP_MAX)
            gap_count++;
         if (flux > cfg_floor && ratio_ok && gap_count >= cfg_gap) begin
            gap_count = '0;
            res.onset = 1'b1;
         end
      end
      res.flux = flux;
      return 1'b1;
   endfunction

   // Offers one bin, after a random number of idle cycles, and waits for its
   // transfer. The predictor is advanced only once the transfer has happened.
   // A frame result typed in the directed table stands in for the predicted one.
   task automatic send_bin(input logic [sfod_pkg::MAG_W-1:0] mag, input logic last,
                           input bit known, input frame_result_type typed_res);
      frame_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= mag;
      req_tlast  <= last;
      @(posedge clock);
      while (req_tready !== 1'b1)
         @(posedge clock);
      bins_sent++;
      if (predict_bin(mag, last, res))
         owed_frames.push_back(known ? typed_res : res);
   endtask

   // Sends one frame of the given length, each magnitude drawn up to level.
   task automatic send_frame(input int len, input int unsigned level);
      logic [sfod_pkg::MAG_W-1:0] mag;
      for (int i = 0; i < len; i++) begin
         mag = sfod_pkg::MAG_W'($urandom_range(0, level));
         send_bin(mag, i == len - 1, 1'b0, '0);
      end
   endtask

   // Sends whole frames until at least n bins have gone. Most frames are
   // short and a few are medium. Levels vary from frame to frame so that
   // quiet frames are followed by loud ones and onsets appear.
   task automatic stream_frames(input int n, input bit one_bin_frames);
      int          sent_here;
      int          len;
      int unsigned level;
      int unsigned pick;
      sent_here = 0;
      while (sent_here < n) begin
         pick = $urandom_range(99);
         if (one_bin_frames)
            len = 1;
         else if (pick < 5)
            len = $urandom_range(13, 48);
         else
            len = $urandom_range(1, 12);
         case ($urandom_range(4))
            0:       level = 0;
            1:       level = 255;
            2:       level = 4095;
            default: level = 65535;
         endcase
         send_frame(len, level);
         sent_here += len;
      end
   endtask

   // Waits until every owed result has been taken, then lets the pipeline
   // drain, since a bin in flight that closes no frame owes nothing.
   task automatic settle();
      while (owed_frames.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Writes all registers back to back, the unused index first so that the
   // real registers are unaffected by it either way.
   task automatic apply_settings(input logic [sfod_pkg::FLUX_W-1:0] floor_val,
                                 input logic [sfod_pkg::SENS_W-1:0] sens_val,
                                 input logic [sfod_pkg::GAP_W-1:0] gap_val);
      csr_we    <= 1'b1;
      csr_index <= CSR_SPARE;
      csr_wdata <= sfod_pkg::CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_index <= sfod_pkg::CSR_FLUX_FLOOR;
      csr_wdata <= floor_val;
      @(posedge clock);
      csr_index <= sfod_pkg::CSR_SENSITIVITY;
      csr_wdata <= sfod_pkg::CSR_DATA_W'(sens_val);
      @(posedge clock);
      csr_index <= sfod_pkg::CSR_MIN_GAP;
      csr_wdata <= sfod_pkg::CSR_DATA_W'(gap_val);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_floor = floor_val;
      cfg_sens  = sens_val;
      cfg_gap   = gap_val;
      settings_applied++;
   endtask

   // ------------------------------------------------------------------------
   // Result side: the receiver stalls at random, and every transfer is
   // checked against the oldest owed result.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      frame_result_type want;
      if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (owed_frames.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, actual flux %0d onset %0b",
                     $time, rsp_tdata[sfod_pkg::FLUX_W-1:0], rsp_tuser[0]);
         end else begin
            want = owed_frames.pop_front();
            frames_checked++;
            if (rsp_tuser[0] === 1'b1)
               onsets_seen++;
            if (rsp_tuser[0] !== want.onset) begin
               mismatch_count++;
               $display("%0t: onset mismatch, expected %0b, actual %0b",
                        $time, want.onset, rsp_tuser[0]);
            end
            if (rsp_tdata[sfod_pkg::FLUX_W-1:0] !== want.flux) begin
               mismatch_count++;
               $display("%0t: frame_flux mismatch, expected %0d, actual %0d",
                        $time, want.flux, rsp_tdata[sfod_pkg::FLUX_W-1:0]);
            end
            if (rsp_tdata[sfod_pkg::RSP_DATA_W-1:sfod_pkg::FLUX_W] !== '0) begin
               mismatch_count++;
               $display("%0t: tdata padding mismatch, expected 0, actual %h",
                        $time, rsp_tdata[sfod_pkg::RSP_DATA_W-1:sfod_pkg::FLUX_W]);
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // ------------------------------------------------------------------------
   // Stimulus. Phases change both the register settings and the balance of
   // stalls; each phase ends on a frame boundary and drains before the next.
   // ------------------------------------------------------------------------
   initial begin
      for (int i = 0; i < BINS; i++)
         prev_mag[i] = '0;
      for (int i = 0; i < DEPTH; i++)
         flux_window[i] = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table with the reset values; the sender waits out the
      // memory sweep through the handshake.
      send_idle_pct = 17;
      recv_idle_pct = 48;
      foreach (directed_rows[i])
         send_bin(directed_rows[i].mag, directed_rows[i].last, directed_rows[i].known,
                  '{onset: directed_rows[i].onset, flux: directed_rows[i].flux});
      req_tvalid <= 1'b0;
      settle();

      // Lowest settings: any rising flux can be an onset, every frame.
      // A frame longer than the memory opens the phase.
      apply_settings('0, '0, '0);
      send_frame(BINS + 2, 65535);
      stream_frames(25, 1'b0);
      req_tvalid <= 1'b0;
      settle();

      // Highest settings: no onset is possible, and enough one-bin frames
      // pass for the gap counter to saturate.
      send_idle_pct = 48;
      recv_idle_pct = 17;
      apply_settings(sfod_pkg::FLUX_MAX, {sfod_pkg::SENS_W{1'b1}}, sfod_pkg::GAP_MAX);
      stream_frames(260, 1'b1);
      req_tvalid <= 1'b0;
      settle();

      // Floor and ratio open, gap at its largest: only a saturated gap
      // counter lets the first rising frame through.
      apply_settings('0, '0, sfod_pkg::GAP_MAX);
      stream_frames(25, 1'b0);
      req_tvalid <= 1'b0;
      settle();

      // No stalls on either side: reset values, then random settings.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_settings(sfod_pkg::FLUX_FLOOR_RST, sfod_pkg::SENSITIVITY_RST,
                     sfod_pkg::MIN_GAP_RST);
      stream_frames(25, 1'b0);
      req_tvalid <= 1'b0;
      settle();

      apply_settings(sfod_pkg::FLUX_W'($urandom_range(0, 200000)),
                     sfod_pkg::SENS_W'($urandom_range(0, 4095)),
                     sfod_pkg::GAP_W'($urandom_range(0, 10)));
      stream_frames(25, 1'b0);
      req_tvalid <= 1'b0;
      settle();
      repeat (10) @(posedge clock);

      $display("Sent %0d bins; checked %0d frame results, %0d of them onsets.",
               bins_sent, frames_checked, onsets_seen);
      $display("Ran %0d register settings under three stall patterns, long frames included.",
               settings_applied);
      if (mismatch_count == 0 && owed_frames.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("Timeout with %0d results still owed.", owed_frames.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/sfod_pkg.sv
rtl/core/sfod_flux.sv
rtl/core/sfod_decide.sv
rtl/core/spectral_flux_onset_detector_top.sv
sim/spectral_flux_onset_detector_top_tb.sv
